// ===== rtl/lrt_pkg.sv =====
package lrt_pkg;

  localparam logic [2:0] FUNC_LOOKUP_VAR  = 3'd0;
  localparam logic [2:0] FUNC_LOOKUP_REL  = 3'd1;
  localparam logic [2:0] FUNC_ENTER_EXT   = 3'd2;
  localparam logic [2:0] FUNC_ENTER_INT   = 3'd3;
  localparam logic [2:0] FUNC_DELETE_REL  = 3'd4;
  localparam logic [2:0] FUNC_RESET_MARKS = 3'd5;
  localparam logic [2:0] FUNC_SEND        = 3'd6;

  localparam logic [3:0] OUT_LIMIT = 4'd8;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  typedef struct packed {
    logic [31:0] var_head;
    logic [63:0] var_tail;
    logic [31:0] rel_head;
    logic [63:0] rel_tail;
    logic [15:0] owner;
    logic [7:0]  attr_count;
    logic [15:0] status;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_load;
    logic shown_last;
  } stat_t;

endpackage

// ===== rtl/lru_name_range_table_core.sv =====
// Lookup, enter, reset marks: word accepted in IDLE, one STEP, then the result is registered and shown.
// Delete: each removed entry takes its own STEP before the single result.
// Send: one result per marked entry (at most OUT_LIMIT), each through STEP and the output handshake.
// One operation at a time: in_stall holds off the next word until the last result is taken.
// Reset (rst, synchronous): entries inactive, marks clear, ranks in slot order, data zero.
module lru_name_range_table_core import lrt_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [31:0] var_head,
  input  logic [63:0] var_tail,
  input  logic [31:0] rel_head,
  input  logic [63:0] rel_tail,
  input  logic [15:0] owner,
  input  logic [7:0]  attr_count,
  input  logic [15:0] rel_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [3:0]  entry_number,
  output logic [31:0] out_var_head,
  output logic [63:0] out_var_tail,
  output logic [31:0] out_rel_head,
  output logic [63:0] out_rel_tail,
  output logic [15:0] out_owner,
  output logic [7:0]  out_attr_count,
  output logic [15:0] out_status,
  output logic        attrs_dropped,
  output logic [3:0]  removed_count,
  output logic        last
);

  cmd_t  cmd;
  stat_t stat;

  lrt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  lrt_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst, .cmd, .stat,
    .func, .var_head, .var_tail, .rel_head, .rel_tail, .owner, .attr_count, .rel_status,
    .hit, .entry_number, .out_var_head, .out_var_tail, .out_rel_head, .out_rel_tail,
    .out_owner, .out_attr_count, .out_status, .attrs_dropped, .removed_count, .last
  );

endmodule

// ===== rtl/lrt_ctrl.sv =====
module lrt_ctrl import lrt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [1:0] {IDLE, STEP, SHOW} state_t;

  state_t state;

  assign cmd.latch = in_valid && !in_stall;
  assign cmd.step  = (state == STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            state    <= STEP;
            in_stall <= 1'b1;
          end
        end
        STEP: begin
          if (stat.out_load) begin
            state     <= SHOW;
            out_valid <= 1'b1;
          end
        end
        SHOW: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (stat.shown_last) begin
              state    <= IDLE;
              in_stall <= 1'b0;
            end else begin
              state <= STEP;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/lrt_datapath.sv =====
module lrt_datapath import lrt_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  func,
  input  logic [31:0] var_head,
  input  logic [63:0] var_tail,
  input  logic [31:0] rel_head,
  input  logic [63:0] rel_tail,
  input  logic [15:0] owner,
  input  logic [7:0]  attr_count,
  input  logic [15:0] rel_status,
  output logic        hit,
  output logic [3:0]  entry_number,
  output logic [31:0] out_var_head,
  output logic [63:0] out_var_tail,
  output logic [31:0] out_rel_head,
  output logic [63:0] out_rel_tail,
  output logic [15:0] out_owner,
  output logic [7:0]  out_attr_count,
  output logic [15:0] out_status,
  output logic        attrs_dropped,
  output logic [3:0]  removed_count,
  output logic        last
);

  localparam int SW = $clog2(ENTRIES + 1);
  localparam int RW = $clog2(ENTRIES);

  logic [2:0]    func_q;
  entry_t        in_q;
  entry_t        table_q [ENTRIES+1];
  logic          active  [ENTRIES+1];
  logic          mark    [ENTRIES+1];
  logic [RW-1:0] rank    [ENTRIES];
  logic [RW-1:0] rank_front [ENTRIES];
  logic [RW-1:0] rank_back  [ENTRIES];
  logic [3:0]    cnt;
  logic [3:0]    sent;
  logic [SW-1:0] ptr;

  logic [ENTRIES-1:0] var_vec, rel_vec, hit_vec, lru_vec, send_vec, above_vec;
  logic [RW-1:0] hit_idx, lru_idx, send_idx, ext_sel;
  logic [SW-1:0] sel;
  logic [RW-1:0] sel_rank;
  logic          any_hit, send_any, more, dropped, show, out_load, out_last;
  entry_t        shown;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      var_vec[i]  = active[i] && table_q[i].var_head == in_q.var_head &&
                    table_q[i].var_tail == in_q.var_tail;
      rel_vec[i]  = active[i] && table_q[i].rel_head == in_q.rel_head &&
                    table_q[i].rel_tail == in_q.rel_tail;
      lru_vec[i]  = (rank[i] == RW'(ENTRIES - 1));
      send_vec[i] = mark[i] && (SW'(i) >= ptr);
    end
    hit_vec = (func_q == FUNC_LOOKUP_REL || func_q == FUNC_DELETE_REL) ? rel_vec : var_vec;
    any_hit  = |hit_vec;
    send_any = |send_vec;
    hit_idx  = '0;
    lru_idx  = '0;
    send_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_idx  = RW'(i);
      if (lru_vec[i])  lru_idx  = RW'(i);
      if (send_vec[i]) send_idx = RW'(i);
    end
    case (func_q)
      FUNC_ENTER_EXT: ext_sel = any_hit ? hit_idx : lru_idx;
      FUNC_SEND:      ext_sel = send_idx;
      default:        ext_sel = hit_idx;
    endcase
    sel      = (func_q == FUNC_ENTER_INT) ? SW'(ENTRIES) : SW'(ext_sel);
    sel_rank = rank[ext_sel];
    for (int i = 0; i < ENTRIES; i++) begin
      rank_front[i] = (rank[i] < sel_rank) ? rank[i] + 1'b1 : rank[i];
      rank_back[i]  = (rank[i] > sel_rank) ? rank[i] - 1'b1 : rank[i];
      above_vec[i]  = mark[i] && (RW'(i) > ext_sel);
    end
    rank_front[ext_sel] = '0;
    rank_back[ext_sel]  = RW'(ENTRIES - 1);
    more    = |above_vec;
    dropped = table_q[sel].rel_head != in_q.rel_head ||
              table_q[sel].rel_tail != in_q.rel_tail ||
              table_q[sel].owner != in_q.owner;
    case (func_q)
      FUNC_LOOKUP_VAR, FUNC_LOOKUP_REL: begin
        show  = any_hit;
        shown = table_q[sel];
      end
      FUNC_ENTER_EXT, FUNC_ENTER_INT: begin
        show  = 1'b1;
        shown = in_q;
      end
      FUNC_SEND: begin
        show  = send_any;
        shown = table_q[sel];
      end
      default: begin
        show  = 1'b0;
        shown = table_q[sel];
      end
    endcase
    out_load = !(func_q == FUNC_DELETE_REL && any_hit);
    out_last = !(func_q == FUNC_SEND && send_any && sent != OUT_LIMIT - 1'b1 && more);
  end

  assign stat.out_load   = out_load;
  assign stat.shown_last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= ENTRIES; i++) begin
        active[i]  <= 1'b0;
        mark[i]    <= 1'b0;
        table_q[i] <= '0;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= RW'(i);
      end
      cnt  <= '0;
      sent <= '0;
      ptr  <= '0;
    end else begin
      if (cmd.latch) begin
        func_q <= func;
        in_q   <= '{var_head, var_tail, rel_head, rel_tail, owner, attr_count, rel_status};
        cnt    <= '0;
        sent   <= '0;
        ptr    <= '0;
      end
      if (cmd.step) begin
        case (func_q)
          FUNC_LOOKUP_VAR, FUNC_LOOKUP_REL: begin
            if (any_hit) begin
              mark[ext_sel] <= 1'b1;
              rank          <= rank_front;
            end
          end
          FUNC_ENTER_EXT: begin
            if (any_hit) mark[ext_sel] <= 1'b1;
            rank         <= rank_front;
            table_q[sel] <= in_q;
            active[sel]  <= 1'b1;
          end
          FUNC_ENTER_INT: begin
            table_q[sel] <= in_q;
            active[sel]  <= 1'b1;
          end
          FUNC_DELETE_REL: begin
            if (any_hit) begin
              table_q[sel].var_head <= '0;
              table_q[sel].var_tail <= '0;
              table_q[sel].rel_head <= '0;
              table_q[sel].rel_tail <= '0;
              mark[sel]   <= 1'b0;
              active[sel] <= 1'b0;
              rank        <= rank_back;
              if (cnt != COUNT_MAX) cnt <= cnt + 1'b1;
            end
          end
          FUNC_RESET_MARKS: begin
            for (int i = 0; i < ENTRIES; i++) mark[i] <= 1'b0;
          end
          FUNC_SEND: begin
            if (send_any) begin
              ptr  <= SW'(ext_sel) + 1'b1;
              sent <= sent + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && out_load) begin
      hit            <= show;
      entry_number   <= show ? ((sel == SW'(ENTRIES)) ? 4'(ENTRIES)
                                : 4'(ENTRIES - 1 - int'(sel))) : 4'd0;
      out_var_head   <= show ? shown.var_head : '0;
      out_var_tail   <= show ? shown.var_tail : '0;
      out_rel_head   <= show ? shown.rel_head : '0;
      out_rel_tail   <= show ? shown.rel_tail : '0;
      out_owner      <= show ? shown.owner : '0;
      out_attr_count <= show ? shown.attr_count : '0;
      out_status     <= show ? shown.status : '0;
      attrs_dropped  <= (func_q == FUNC_ENTER_EXT || func_q == FUNC_ENTER_INT) && dropped;
      removed_count  <= (func_q == FUNC_DELETE_REL) ? cnt : 4'd0;
      last           <= out_last;
    end
  end

endmodule

// ===== rtl/lrt_checker.sv =====
module lrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic [3:0]  entry_number,
  input logic [15:0] out_owner,
  input logic        attrs_dropped,
  input logic [3:0]  removed_count,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result word dropped while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> entry_number == 4'd0 && out_owner == 16'd0 && !attrs_dropped)
    else $error("miss word carries entry data");

  a_count_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && removed_count != 4'd0 |-> !hit && last)
    else $error("delete count on a non-final or hit word");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while a result is pending");

endmodule

bind lru_name_range_table_core lrt_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .hit, .entry_number,
  .out_owner, .attrs_dropped, .removed_count, .last
);

// ===== sim/lru_name_range_table_core_test.sv =====
`timescale 1ns / 100ps

module lru_name_range_table_core_test;
  import lrt_pkg::*;

  localparam int ENTRIES = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [2:0] FUNC_UNKNOWN = 3'd7;

  typedef struct packed {
    logic        hit;
    logic [3:0]  entry_number;
    logic [31:0] var_head;
    logic [63:0] var_tail;
    logic [31:0] rel_head;
    logic [63:0] rel_tail;
    logic [15:0] owner;
    logic [7:0]  attr_count;
    logic [15:0] status;
    logic        attrs_dropped;
    logic [3:0]  removed_count;
    logic        last;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] func = '0;
  logic [31:0] var_head = '0;
  logic [63:0] var_tail = '0;
  logic [31:0] rel_head = '0;
  logic [63:0] rel_tail = '0;
  logic [15:0] owner = '0;
  logic [7:0] attr_count = '0;
  logic [15:0] rel_status = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [3:0] entry_number;
  logic [31:0] out_var_head;
  logic [63:0] out_var_tail;
  logic [31:0] out_rel_head;
  logic [63:0] out_rel_tail;
  logic [15:0] out_owner;
  logic [7:0] out_attr_count;
  logic [15:0] out_status;
  logic attrs_dropped;
  logic [3:0] removed_count;
  logic last;

  lru_name_range_table_core #(.ENTRIES(ENTRIES)) dut (.*);

  always #10 clk = ~clk;

  // table mirror
  logic        tb_active [ENTRIES+1];
  logic        tb_mark [ENTRIES+1];
  logic [2:0]  tb_rank [ENTRIES];
  entry_t      tb_entry [ENTRIES+1];

  table_reply_t expected_replies[$];
  int errors = 0;
  int words_sent = 0;
  int replies_seen = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit idling_on = 1'b1;
  bit finished = 1'b0;

  // name pools keep hits frequent
  logic [31:0] var_heads [4];
  logic [63:0] var_tails [4];
  logic [31:0] rel_heads [3];
  logic [63:0] rel_tails [3];

  function automatic void mirror_reset();
    for (int i = 0; i <= ENTRIES; i++) begin
      tb_active[i] = 1'b0;
      tb_mark[i] = 1'b0;
      tb_entry[i] = '0;
    end
    for (int i = 0; i < ENTRIES; i++) tb_rank[i] = i[2:0];
  endfunction

  function automatic void move_front(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (tb_rank[i] < tb_rank[s]) tb_rank[i]++;
    tb_rank[s] = 0;
  endfunction

  function automatic void move_back(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (tb_rank[i] > tb_rank[s]) tb_rank[i]--;
    tb_rank[s] = 3'(ENTRIES - 1);
  endfunction

  function automatic int find_slot(bit by_rel, logic [31:0] h, logic [63:0] t);
    logic eq;
    for (int i = 0; i < ENTRIES; i++) begin
      eq = by_rel ? (tb_entry[i].rel_head == h && tb_entry[i].rel_tail == t)
                  : (tb_entry[i].var_head == h && tb_entry[i].var_tail == t);
      if (tb_active[i] && eq) begin
        tb_mark[i] = 1'b1;
        move_front(i);
        return i;
      end
    end
    return -1;
  endfunction

  function automatic table_reply_t entry_reply(int s);
    table_reply_t r = '0;
    r.hit = 1'b1;
    r.entry_number = (s == ENTRIES) ? 4'(ENTRIES) : 4'(ENTRIES - 1 - s);
    r.var_head = tb_entry[s].var_head;
    r.var_tail = tb_entry[s].var_tail;
    r.rel_head = tb_entry[s].rel_head;
    r.rel_tail = tb_entry[s].rel_tail;
    r.owner = tb_entry[s].owner;
    r.attr_count = tb_entry[s].attr_count;
    r.status = tb_entry[s].status;
    return r;
  endfunction

  function automatic void predict_table(logic [2:0] f, entry_t w);
    table_reply_t r = '0;
    int s, n;
    logic dropped;
    case (f)
      FUNC_LOOKUP_VAR, FUNC_LOOKUP_REL: begin
        s = (f == FUNC_LOOKUP_VAR) ? find_slot(0, w.var_head, w.var_tail)
                                   : find_slot(1, w.rel_head, w.rel_tail);
        if (s >= 0) r = entry_reply(s);
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      FUNC_ENTER_EXT, FUNC_ENTER_INT: begin
        if (f == FUNC_ENTER_INT) begin
          s = ENTRIES;
        end else begin
          s = find_slot(0, w.var_head, w.var_tail);
          if (s < 0) begin
            s = 0;
            for (int i = ENTRIES - 1; i >= 0; i--)
              if (tb_rank[i] == 3'(ENTRIES - 1)) s = i;
          end
          move_front(s);
        end
        dropped = tb_entry[s].rel_head != w.rel_head
                  || tb_entry[s].rel_tail != w.rel_tail
                  || tb_entry[s].owner != w.owner;
        tb_entry[s] = w;
        tb_active[s] = 1'b1;
        r = entry_reply(s);
        r.attrs_dropped = dropped;
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      FUNC_DELETE_REL: begin
        n = 0;
        s = find_slot(1, w.rel_head, w.rel_tail);
        while (s >= 0) begin
          tb_entry[s].var_head = '0;
          tb_entry[s].var_tail = '0;
          tb_entry[s].rel_head = '0;
          tb_entry[s].rel_tail = '0;
          tb_mark[s] = 1'b0;
          tb_active[s] = 1'b0;
          move_back(s);
          n++;
          s = find_slot(1, w.rel_head, w.rel_tail);
        end
        r.removed_count = (n > 15) ? COUNT_MAX : 4'(n);
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      FUNC_RESET_MARKS: begin
        for (int i = 0; i < ENTRIES; i++) tb_mark[i] = 1'b0;
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      FUNC_SEND: begin
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
          if (tb_mark[i] && n < OUT_LIMIT) begin
            r = entry_reply(i);
            expected_replies.push_back(r);
            n++;
          end
        if (n == 0) begin
          r = '0;
          r.last = 1'b1;
          expected_replies.push_back(r);
        end else begin
          expected_replies[$].last = 1'b1;
        end
      end
      default: begin
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
    endcase
  endfunction

  task automatic send_word(logic [2:0] f, entry_t w);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    func <= f;
    var_head <= w.var_head;
    var_tail <= w.var_tail;
    rel_head <= w.rel_head;
    rel_tail <= w.rel_tail;
    owner <= w.owner;
    attr_count <= w.attr_count;
    rel_status <= w.status;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_table(f, w);
    words_sent++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic entry_t random_word();
    entry_t w;
    int k;
    w.owner = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom);
    w.attr_count = 8'($urandom);
    w.status = 16'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      w.var_head = $urandom;
      w.var_tail = {$urandom, $urandom};
      w.rel_head = $urandom;
      w.rel_tail = {$urandom, $urandom};
    end else begin
      k = $urandom_range(0, 3);
      w.var_head = var_heads[k];
      w.var_tail = var_tails[k];
      k = $urandom_range(0, 2);
      w.rel_head = rel_heads[k];
      w.rel_tail = rel_tails[k];
    end
    return w;
  endfunction

  task automatic wait_drained();
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    entry_t w;
    w = '0;
    send_word(FUNC_LOOKUP_VAR, w);
    send_word(FUNC_LOOKUP_REL, w);
    send_word(FUNC_SEND, w);
    send_word(FUNC_DELETE_REL, w);
    send_word(FUNC_ENTER_INT, w);
    w = '1;
    send_word(FUNC_ENTER_INT, w);
    send_word(FUNC_ENTER_EXT, w);
    send_word(FUNC_ENTER_EXT, w);
    send_word(FUNC_LOOKUP_VAR, w);
    w.owner = 16'h0;
    send_word(FUNC_ENTER_EXT, w);
    for (int i = 0; i < 9; i++) begin
      w = '0;
      w.var_head = 32'(i + 1);
      w.var_tail = {32'hFFFF_FFFF, 32'(i)};
      w.rel_head = 32'h8000_0000;
      w.rel_tail = 64'h8000_0000_0000_0001;
      w.owner = 16'hFFFF;
      w.attr_count = 8'(i);
      w.status = 16'h8000;
      send_word(FUNC_ENTER_EXT, w);
    end
    send_word(FUNC_SEND, w);
    send_word(FUNC_LOOKUP_REL, w);
    send_word(FUNC_RESET_MARKS, w);
    send_word(FUNC_SEND, w);
    send_word(FUNC_DELETE_REL, w);
    send_word(FUNC_UNKNOWN, w);
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [2:0] f;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: f = FUNC_ENTER_EXT;
        5:              f = FUNC_ENTER_INT;
        6, 7, 8:        f = FUNC_LOOKUP_VAR;
        9, 10:          f = FUNC_LOOKUP_REL;
        11:             f = FUNC_DELETE_REL;
        12:             f = FUNC_RESET_MARKS;
        13, 14:         f = FUNC_SEND;
        default:        f = 3'($urandom_range(0, 7));
      endcase
      send_word(f, random_word());
    end
  endtask

  always @(posedge clk) begin
    table_reply_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {hit, entry_number, out_var_head, out_var_tail, out_rel_head, out_rel_tail,
             out_owner, out_attr_count, out_status, attrs_dropped, removed_count, last};
      replies_seen++;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rst || !idling_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT && !finished) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) begin
      var_heads[i] = $urandom;
      var_tails[i] = {$urandom, $urandom};
    end
    for (int i = 0; i < 3; i++) begin
      rel_heads[i] = $urandom;
      rel_tails[i] = {$urandom, $urandom};
    end
    mirror_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100);
    wait_drained();
    test_random(55);
    idling_on = 1'b0;
    test_random(50);
    wait_drained();
    repeat (20) @(posedge clk);
    finished = 1'b1;
    $display("Covered %0d words and %0d results: lookups, enters, deletes, marks, sends.",
             words_sent, replies_seen);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lrt_pkg.sv
rtl/lrt_ctrl.sv
rtl/lrt_datapath.sv
rtl/lru_name_range_table_core.sv
rtl/lrt_checker.sv
sim/lru_name_range_table_core_test.sv
